// ===== rtl/tlv_certificate_field_extractor_defines.svh =====
// Assertion helpers for the extractor RTL.
`ifndef TLV_CERTIFICATE_FIELD_EXTRACTOR_DEFINES_SVH
`define TLV_CERTIFICATE_FIELD_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcfe: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TCFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcfe: next-cycle check failed");

`endif

// ===== rtl/tcfe_pkg.sv =====
`default_nettype none
package tcfe_pkg;

  typedef enum logic [2:0] {
    ET_END    = 3'd0,
    ET_STRUCT = 3'd1,
    ET_ARRAY  = 3'd2,
    ET_LIST   = 3'd3,
    ET_BYTES  = 3'd4,
    ET_BOOL   = 3'd5,
    ET_OTHER  = 3'd6
  } elem_type_e;

  typedef enum logic [2:0] {
    MODE_WAIT  = 3'd0,
    MODE_TOP   = 3'd1,
    MODE_SUBJ  = 3'd2,
    MODE_ISS   = 3'd3,
    MODE_EXT   = 3'd4,
    MODE_BASIC = 3'd5,
    MODE_SKIP  = 3'd6
  } parse_mode_e;

  typedef enum logic [1:0] {
    TGT_NONE   = 2'd0,
    TGT_SERIAL = 2'd1,
    TGT_PUBKEY = 2'd2,
    TGT_SIG    = 2'd3
  } capture_target_e;

  typedef enum logic [3:0] {
    KIND_NONE       = 4'd0,
    KIND_SUBJ_NODE  = 4'd1,
    KIND_SUBJ_FAB   = 4'd2,
    KIND_SUBJ_RCAC  = 4'd3,
    KIND_SUBJ_ICAC  = 4'd4,
    KIND_ISS_RCAC   = 4'd5,
    KIND_ISS_ICAC   = 4'd6,
    KIND_NOT_BEFORE = 4'd7,
    KIND_NOT_AFTER  = 4'd8,
    KIND_IS_CA      = 4'd9
  } field_kind_e;

  // Top-level certificate tags
  localparam logic [7:0] TAG_SERIAL      = 8'd1;
  localparam logic [7:0] TAG_ISSUER      = 8'd3;
  localparam logic [7:0] TAG_VALID_FROM  = 8'd4;
  localparam logic [7:0] TAG_VALID_UNTIL = 8'd5;
  localparam logic [7:0] TAG_SUBJECT     = 8'd6;
  localparam logic [7:0] TAG_PUB_KEY     = 8'd9;
  localparam logic [7:0] TAG_EXTENSIONS  = 8'd10;
  localparam logic [7:0] TAG_SIGNATURE   = 8'd11;
  // Distinguished-name attribute tags
  localparam logic [7:0] ATTR_NODE_ID    = 8'd17;
  localparam logic [7:0] ATTR_ICAC_ID    = 8'd19;
  localparam logic [7:0] ATTR_RCAC_ID    = 8'd20;
  localparam logic [7:0] ATTR_FABRIC_ID  = 8'd21;
  // Extension tags
  localparam logic [7:0] EXT_BASIC_CONSTR = 8'd1;
  localparam logic [7:0] EXT_CA_FLAG      = 8'd1;

  localparam logic [15:0] PUBKEY_LEN = 16'd65;
  localparam logic [15:0] SIG_LEN    = 16'd64;

  // Presence flag bit positions
  localparam int unsigned PB_NODE   = 0;
  localparam int unsigned PB_FABRIC = 1;
  localparam int unsigned PB_RCAC   = 2;
  localparam int unsigned PB_ICAC   = 3;
  localparam int unsigned PB_I_RCAC = 4;
  localparam int unsigned PB_I_ICAC = 5;
  localparam int unsigned PB_KEY    = 6;
  localparam int unsigned PB_SIG    = 7;

  localparam int unsigned QDEPTH = 2;

  // One element after classification
  typedef struct packed {
    elem_type_e  etype;
    logic        is_ctx;
    logic        is_container;
    logic        hit_serial;
    logic        hit_issuer;
    logic        hit_valid_from;
    logic        hit_valid_until;
    logic        hit_subject;
    logic        hit_pub_key;
    logic        hit_ext;
    logic        hit_sig;
    logic        hit_basic;
    logic        hit_ca_flag;
    logic        hit_node;
    logic        hit_fabric;
    logic        hit_rcac;
    logic        hit_icac;
    logic        serial_fit;
    logic [4:0]  ser_bytes;
    logic        key_len_ok;
    logic        sig_len_ok;
    logic        val_nz;
    logic [63:0] value;
    logic        no_more;
    logic        reader_error;
  } elem_cls_t;

  typedef struct packed {
    capture_target_e target;
    field_kind_e     kind;
    logic [63:0]     fval;
    logic [7:0]      present;
    logic            ca;
    logic [4:0]      ser_count;
    logic            done;
    logic            accepted;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ===== rtl/tcfe_front.sv =====
`default_nettype none
module tcfe_front #(
  parameter int unsigned SERIAL_MAX = 20
) (
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [2:0]           elem_type_i,
  input  wire logic                 tag_is_context_i,
  input  wire logic [7:0]           tag_number_i,
  input  wire logic [63:0]          value_i,
  input  wire logic [15:0]          payload_len_i,
  input  wire logic                 no_more_i,
  input  wire logic                 reader_error_i,
  input  wire tcfe_pkg::q_status_t  q_status_i,
  output logic                      push_o,
  output tcfe_pkg::elem_cls_t       cls_o
);
  import tcfe_pkg::*;

  localparam logic [15:0] SerialMax = 16'(SERIAL_MAX);

  elem_type_e etype;

  // Fold the unused type code onto "other scalar"
  always_comb begin
    case (elem_type_i)
      ET_END:    etype = ET_END;
      ET_STRUCT: etype = ET_STRUCT;
      ET_ARRAY:  etype = ET_ARRAY;
      ET_LIST:   etype = ET_LIST;
      ET_BYTES:  etype = ET_BYTES;
      ET_BOOL:   etype = ET_BOOL;
      default:   etype = ET_OTHER;
    endcase
  end

  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    cls_o                 = '0;
    cls_o.etype           = etype;
    cls_o.is_ctx          = tag_is_context_i;
    cls_o.is_container    = (etype == ET_STRUCT) || (etype == ET_ARRAY) || (etype == ET_LIST);
    cls_o.hit_serial      = (tag_number_i == TAG_SERIAL);
    cls_o.hit_issuer      = (tag_number_i == TAG_ISSUER);
    cls_o.hit_valid_from  = (tag_number_i == TAG_VALID_FROM);
    cls_o.hit_valid_until = (tag_number_i == TAG_VALID_UNTIL);
    cls_o.hit_subject     = (tag_number_i == TAG_SUBJECT);
    cls_o.hit_pub_key     = (tag_number_i == TAG_PUB_KEY);
    cls_o.hit_ext         = (tag_number_i == TAG_EXTENSIONS);
    cls_o.hit_sig         = (tag_number_i == TAG_SIGNATURE);
    cls_o.hit_basic       = (tag_number_i == EXT_BASIC_CONSTR);
    cls_o.hit_ca_flag     = (tag_number_i == EXT_CA_FLAG);
    cls_o.hit_node        = (tag_number_i == ATTR_NODE_ID);
    cls_o.hit_fabric      = (tag_number_i == ATTR_FABRIC_ID);
    cls_o.hit_rcac        = (tag_number_i == ATTR_RCAC_ID);
    cls_o.hit_icac        = (tag_number_i == ATTR_ICAC_ID);
    cls_o.serial_fit      = (payload_len_i <= SerialMax);
    cls_o.ser_bytes       = payload_len_i[4:0];
    cls_o.key_len_ok      = (payload_len_i == PUBKEY_LEN);
    cls_o.sig_len_ok      = (payload_len_i == SIG_LEN);
    cls_o.val_nz          = (value_i != 64'd0);
    cls_o.value           = value_i;
    cls_o.no_more         = no_more_i;
    cls_o.reader_error    = reader_error_i;
  end

endmodule
`default_nettype wire

// ===== rtl/tcfe_queue.sv =====
`default_nettype none
module tcfe_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire tcfe_pkg::elem_cls_t  wr_data_i,
  input  wire logic                 pop_i,
  output tcfe_pkg::elem_cls_t       rd_data_o,
  output tcfe_pkg::q_status_t       status_o
);
  import tcfe_pkg::*;

  localparam int unsigned PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(QDEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(QDEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(QDEPTH);

  elem_cls_t       entry_q [QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == Full);
  assign status_o.empty = (count_q == '0);
  assign rd_data_o      = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tcfe_back.sv =====
`default_nettype none
module tcfe_back #(
  parameter int unsigned MAX_SKIP_DEPTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tcfe_pkg::elem_cls_t  elem_i,
  input  wire tcfe_pkg::q_status_t  q_status_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output tcfe_pkg::result_t         result_o
);
  import tcfe_pkg::*;

  localparam logic [4:0] MaxDepth = 5'(MAX_SKIP_DEPTH);

  parse_mode_e mode_q, mode_d, mode_upd;
  logic [4:0]  depth_q, depth_d, depth_upd;
  logic        ret_ext_q, ret_ext_d, ret_ext_upd;
  logic [7:0]  pres_q, pres_d, pres_upd;
  logic        ca_q, ca_d, ca_upd;
  logic [4:0]  serial_q, serial_d, serial_upd;
  logic        err_q, err_d, err_upd;
  logic        cert_end;
  logic        subj;

  logic        out_valid_q;
  result_t     result_q, result_d;

  // Advance one element whenever the queue holds one and the output register is free or draining
  assign pop_o       = !q_status_i.empty && (!out_valid_q || out_ready_i);
  assign subj        = (mode_q == MODE_SUBJ);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // Next state: context walk
  always_comb begin
    mode_upd    = mode_q;
    depth_upd   = depth_q;
    ret_ext_upd = ret_ext_q;
    pres_upd    = pres_q;
    ca_upd      = ca_q;
    serial_upd  = serial_q;
    err_upd     = err_q;
    cert_end    = 1'b0;

    if (elem_i.no_more || elem_i.reader_error) begin
      if (elem_i.reader_error) begin
        err_upd = 1'b1;
      end
      cert_end = 1'b1;
    end else begin
      case (mode_q)
        MODE_TOP: begin
          if (elem_i.etype == ET_END) begin
            cert_end = 1'b1;
          end else if (elem_i.hit_serial && elem_i.etype == ET_BYTES) begin
            if (elem_i.serial_fit) begin
              serial_upd = elem_i.ser_bytes;
            end
          end else if ((elem_i.hit_valid_from || elem_i.hit_valid_until) &&
                       !elem_i.is_container) begin
            mode_upd = mode_q;
          end else if ((elem_i.hit_issuer || elem_i.hit_subject) && elem_i.etype == ET_LIST) begin
            mode_upd = elem_i.hit_subject ? MODE_SUBJ : MODE_ISS;
          end else if (elem_i.hit_ext && elem_i.etype == ET_LIST) begin
            mode_upd = MODE_EXT;
          end else if (elem_i.hit_pub_key && elem_i.etype == ET_BYTES) begin
            if (elem_i.key_len_ok) begin
              pres_upd[PB_KEY] = 1'b1;
            end
          end else if (elem_i.hit_sig && elem_i.etype == ET_BYTES) begin
            if (elem_i.sig_len_ok) begin
              pres_upd[PB_SIG] = 1'b1;
            end
          end else if (elem_i.is_container) begin
            mode_upd    = MODE_SKIP;
            depth_upd   = 5'd1;
            ret_ext_upd = 1'b0;
          end
        end
        MODE_SUBJ, MODE_ISS: begin
          if (elem_i.etype == ET_END) begin
            mode_upd = MODE_TOP;
          end else if (elem_i.is_ctx) begin
            if (elem_i.hit_node && subj) begin
              pres_upd[PB_NODE] = 1'b1;
            end else if (elem_i.hit_fabric && subj) begin
              pres_upd[PB_FABRIC] = 1'b1;
            end else if (elem_i.hit_rcac) begin
              if (subj) pres_upd[PB_RCAC] = 1'b1;
              else      pres_upd[PB_I_RCAC] = 1'b1;
            end else if (elem_i.hit_icac) begin
              if (subj) pres_upd[PB_ICAC] = 1'b1;
              else      pres_upd[PB_I_ICAC] = 1'b1;
            end
          end
        end
        MODE_EXT: begin
          if (elem_i.etype == ET_END) begin
            mode_upd = MODE_TOP;
          end else if (elem_i.etype == ET_STRUCT && elem_i.is_ctx && elem_i.hit_basic) begin
            mode_upd = MODE_BASIC;
          end else if (elem_i.is_container) begin
            mode_upd    = MODE_SKIP;
            depth_upd   = 5'd1;
            ret_ext_upd = 1'b1;
          end
        end
        MODE_BASIC: begin
          if (elem_i.etype == ET_END) begin
            mode_upd = MODE_EXT;
          end else if (elem_i.etype == ET_BOOL && elem_i.is_ctx && elem_i.hit_ca_flag) begin
            ca_upd = elem_i.val_nz;
          end
        end
        MODE_SKIP: begin
          if (elem_i.is_container) begin
            if (depth_q < MaxDepth) begin
              depth_upd = depth_q + 5'd1;
            end
            if (depth_upd >= MaxDepth) begin
              err_upd = 1'b1;
            end
          end else if (elem_i.etype == ET_END) begin
            if (depth_q != 5'd0) begin
              depth_upd = depth_q - 5'd1;
            end
            if (depth_upd == 5'd0) begin
              mode_upd = ret_ext_q ? MODE_EXT : MODE_TOP;
            end
          end
        end
        default: begin
          if (elem_i.etype == ET_STRUCT) begin
            mode_upd = MODE_TOP;
          end else begin
            cert_end = 1'b1;
          end
        end
      endcase
    end

    // Closing a certificate drops every piece of context
    if (cert_end) begin
      mode_d    = MODE_WAIT;
      depth_d   = '0;
      ret_ext_d = 1'b0;
      pres_d    = '0;
      ca_d      = 1'b0;
      serial_d  = '0;
      err_d     = 1'b0;
    end else begin
      mode_d    = mode_upd;
      depth_d   = depth_upd;
      ret_ext_d = ret_ext_upd;
      pres_d    = pres_upd;
      ca_d      = ca_upd;
      serial_d  = serial_upd;
      err_d     = err_upd;
    end
  end

  // Outputs: the field that this element sets
  always_comb begin
    result_d            = '0;
    result_d.target     = TGT_NONE;
    result_d.kind       = KIND_NONE;
    result_d.present    = pres_upd;
    result_d.ca         = ca_upd;
    result_d.ser_count  = serial_upd;
    result_d.done       = cert_end;
    result_d.accepted   = cert_end && !err_upd && pres_upd[PB_KEY];

    if (!elem_i.no_more && !elem_i.reader_error) begin
      case (mode_q)
        MODE_TOP: begin
          if (elem_i.etype == ET_END) begin
            result_d.target = TGT_NONE;
          end else if (elem_i.hit_serial && elem_i.etype == ET_BYTES) begin
            if (elem_i.serial_fit) result_d.target = TGT_SERIAL;
          end else if ((elem_i.hit_valid_from || elem_i.hit_valid_until) &&
                       !elem_i.is_container) begin
            result_d.kind = elem_i.hit_valid_from ? KIND_NOT_BEFORE : KIND_NOT_AFTER;
            result_d.fval = {32'd0, elem_i.value[31:0]};
          end else if (elem_i.hit_pub_key && elem_i.etype == ET_BYTES) begin
            if (elem_i.key_len_ok) result_d.target = TGT_PUBKEY;
          end else if (elem_i.hit_sig && elem_i.etype == ET_BYTES) begin
            if (elem_i.sig_len_ok) result_d.target = TGT_SIG;
          end
        end
        MODE_SUBJ, MODE_ISS: begin
          if (elem_i.etype != ET_END && elem_i.is_ctx) begin
            if (elem_i.hit_node && subj) begin
              result_d.kind = KIND_SUBJ_NODE;
            end else if (elem_i.hit_fabric && subj) begin
              result_d.kind = KIND_SUBJ_FAB;
            end else if (elem_i.hit_rcac) begin
              result_d.kind = subj ? KIND_SUBJ_RCAC : KIND_ISS_RCAC;
            end else if (elem_i.hit_icac) begin
              result_d.kind = subj ? KIND_SUBJ_ICAC : KIND_ISS_ICAC;
            end
            if (result_d.kind != KIND_NONE) result_d.fval = elem_i.value;
          end
        end
        MODE_BASIC: begin
          if (elem_i.etype == ET_BOOL && elem_i.is_ctx && elem_i.hit_ca_flag) begin
            result_d.kind = KIND_IS_CA;
            result_d.fval = {63'd0, elem_i.val_nz};
          end
        end
        default: begin
          result_d.kind = KIND_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_WAIT;
      depth_q     <= '0;
      ret_ext_q   <= 1'b0;
      pres_q      <= '0;
      ca_q        <= 1'b0;
      serial_q    <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q    <= mode_d;
        depth_q   <= depth_d;
        ret_ext_q <= ret_ext_d;
        pres_q    <= pres_d;
        ca_q      <= ca_d;
        serial_q  <= serial_d;
        err_q     <= err_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= result_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tlv_certificate_field_extractor.sv =====
// Channel   Dir  Handshake              Contents
// s_axis    in   tvalid/tready, tlast   one decoded TLV element; tlast = no further element
// m_axis    out  tvalid/tready, tlast   one result per element; tlast = certificate closed
//
// Throughput is one element per cycle while the output is not stalled. The
// accepting edge writes the classified element into the two-entry queue, and
// the context walk then carries it from the queue into the output register.
// The context walk is a single state update per element and sets the rate.
// Reset clears the queue, the context and the output valid; no clearing pass.
// A stalled output holds its result; the queue keeps absorbing input until full.
`default_nettype none
`include "tlv_certificate_field_extractor_defines.svh"
module tlv_certificate_field_extractor #(
  parameter int unsigned SERIAL_MAX     = 20,
  parameter int unsigned MAX_SKIP_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input element transaction
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [7:0] tag_number, [71:8] value, [87:72] payload_len
  input  wire logic [87:0] s_axis_tdata_i,
  // [2:0] elem_type, [3] tag_is_context, [4] reader_error
  input  wire logic [4:0]  s_axis_tuser_i,
  // no_more
  input  wire logic        s_axis_tlast_i,
  // Result transaction
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [63:0] field_value, [71:64] present_flags, [72] ca_flag,
  // [77:73] serial_length, [78] accepted, [79] zero
  output logic [79:0]      m_axis_tdata_o,
  // [1:0] capture_target, [5:2] field_kind
  output logic [5:0]       m_axis_tuser_o,
  // done_res
  output logic             m_axis_tlast_o
);
  import tcfe_pkg::*;

  q_status_t q_status;
  elem_cls_t cls_in;
  elem_cls_t cls_head;
  logic      push;
  logic      pop;
  result_t   result;

  // Front: take the transaction and classify tags, lengths and type
  tcfe_front #(
    .SERIAL_MAX (SERIAL_MAX)
  ) u_front (
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .elem_type_i      (s_axis_tuser_i[2:0]),
    .tag_is_context_i (s_axis_tuser_i[3]),
    .tag_number_i     (s_axis_tdata_i[7:0]),
    .value_i          (s_axis_tdata_i[71:8]),
    .payload_len_i    (s_axis_tdata_i[87:72]),
    .no_more_i        (s_axis_tlast_i),
    .reader_error_i   (s_axis_tuser_i[4]),
    .q_status_i       (q_status),
    .push_o           (push),
    .cls_o            (cls_in)
  );

  // Decouple front and back so either side can stall alone
  tcfe_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (cls_in),
    .pop_i     (pop),
    .rd_data_o (cls_head),
    .status_o  (q_status)
  );

  // Back: walk the certificate context and register the result
  tcfe_back #(
    .MAX_SKIP_DEPTH (MAX_SKIP_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .elem_i      (cls_head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result)
  );

  // Pack the result fields onto the bus
  assign m_axis_tdata_o = {1'b0, result.accepted, result.ser_count, result.ca,
                           result.present, result.fval};
  assign m_axis_tuser_o = {result.kind, result.target};
  assign m_axis_tlast_o = result.done;

  // Acceptance needs the public key flag
  `TCFE_ASSERT_NOW(a_accept_needs_key, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[78], m_axis_tdata_o[64 + PB_KEY])
  // An isCA result carries the same bit as the reported isCA flag
  `TCFE_ASSERT_NOW(a_isca_matches_flag, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o[5:2] == KIND_IS_CA), m_axis_tdata_o[0] == m_axis_tdata_o[72])
  // Field reports and payload captures never share one result
  `TCFE_ASSERT_NOW(a_kind_or_capture, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o[5:2] != KIND_NONE), m_axis_tuser_o[1:0] == TGT_NONE)
  // Full queue behind a stalled output keeps the input blocked
  `TCFE_ASSERT_NEXT(a_backpressure_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i && q_status.full, !s_axis_tready_o)

endmodule
`default_nettype wire
